### sv/nv12_to_rgb_converter_defines.svh
// Assertion macros for the NV12 to RGB converter.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef NV12_TO_RGB_CONVERTER_DEFINES_SVH
`define NV12_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define NV12R_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define NV12R_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/nv12r_pkg.sv
// Shared types and constants of the NV12 to RGB converter.
// No dependencies; used by every module of the block except nv12r_fifo.
`timescale 1ns / 1ps

package nv12r_pkg;

	// Item kinds on the input side.
	typedef enum logic {
		OP_CHROMA = 1'b0,
		OP_LUMA   = 1'b1
	} op_t;

	// Configuration register indexes.
	localparam int REG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [REG_INDEX_W-1:0] REG_CHANNEL_ORDER = 2'd2;

	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

	// Queue depths between front and back and on the result side.
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// BT.601 limited-range Q8 coefficients.
	typedef logic signed [9:0]  sample_t;
	typedef logic signed [19:0] acc_t;
	localparam logic signed [10:0] K_LUMA     = 11'sd298;
	localparam logic signed [10:0] K_RED_CR   = 11'sd409;
	localparam logic signed [10:0] K_GREEN_CB = 11'sd100;
	localparam logic signed [10:0] K_GREEN_CR = 11'sd208;
	localparam logic signed [10:0] K_BLUE_CB  = 11'sd517;
	localparam logic signed [9:0]  LUMA_OFFSET   = 10'sd16;
	localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;
	localparam acc_t ROUND_HALF = 20'sd128;

	// Classified item passed from front to back (address travels beside it).
	typedef struct packed {
		op_t         opcode;
		logic        end_of_row;
		logic        end_of_image;
		logic [15:0] data;
	} item_t;

	// One finished pixel.
	typedef struct packed {
		logic [7:0] first_channel;
		logic [7:0] middle_channel;
		logic [7:0] last_channel;
		logic       end_of_row;
		logic       end_of_image;
	} pixel_t;

	// Round, floor-divide by 256 and limit to 0..255.
	function automatic logic [7:0] clamp_q8(input acc_t acc);
		acc_t t;
		t = acc + ROUND_HALF;
		if (t[19]) begin
			return 8'd0;
		end else if (t[18:16] != 3'd0) begin
			return 8'hFF;
		end else begin
			return t[15:8];
		end
	endfunction

endpackage

### sv/nv12r_fifo.sv
// Small first-in first-out queue built from registers.
// No dependencies; used between front and back and on the result side.
`timescale 1ns / 1ps

module nv12r_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = buf_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// Store a beat.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### sv/nv12r_front.sv
// Front end: accepts input beats, tracks column, row and chroma write slot,
// and classifies each beat into a queue item. Uses nv12r_pkg.
`timescale 1ns / 1ps

module nv12r_front #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 q_full,
	input  logic [0:0]                           opcode,
	input  logic [7:0]                           luma,
	input  logic [7:0]                           chroma_blue,
	input  logic [7:0]                           chroma_red,
	input  logic [nv12r_pkg::WIDTH_REG_W-1:0]    image_width,
	input  logic [nv12r_pkg::HEIGHT_REG_W-1:0]   image_height,
	output logic                                 q_write,
	output nv12r_pkg::item_t                     q_item,
	output logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] q_addr
);

	localparam int LD    = MAX_WIDTH / 2;
	localparam int AW    = (LD > 1) ? $clog2(LD) : 1;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int WW    = (CNT_W > nv12r_pkg::WIDTH_REG_W) ? CNT_W : nv12r_pkg::WIDTH_REG_W;
	localparam int HW    = nv12r_pkg::HEIGHT_REG_W;
	localparam logic [WW-1:0]    MAX_EVEN  = WW'(MAX_WIDTH - (MAX_WIDTH % 2));
	localparam logic [COL_W-1:0] LAST_SLOT = COL_W'(LD - 1);

	logic [COL_W-1:0] col_q;
	logic [HW-1:0]    row_q;
	logic [AW-1:0]    wp_q;

	logic [WW-1:0]    w_even;
	logic [WW-1:0]    act_width;
	logic [HW-1:0]    act_height;
	logic [WW:0]      col_next;
	logic [HW:0]      row_next;
	logic             eor;
	logic             eoi;
	logic [COL_W-1:0] slot;
	logic [AW:0]      wp_inc;
	logic [AW-1:0]    wp_next;
	logic             accept;
	logic             is_luma;

	assign accept  = push && !q_full;
	assign is_luma = (nv12r_pkg::op_t'(opcode) == nv12r_pkg::OP_LUMA);

	// Limit width to an even value in 2..MAX_WIDTH; zero height counts as one.
	always_comb begin
		w_even = WW'({image_width[nv12r_pkg::WIDTH_REG_W-1:1], 1'b0});
		if (w_even < WW'(2)) begin
			act_width = WW'(2);
		end else if (w_even > MAX_EVEN) begin
			act_width = MAX_EVEN;
		end else begin
			act_width = w_even;
		end
		act_height = (image_height == '0) ? HW'(1) : image_height;
	end

	// Row and image ends, read slot and next write slot.
	always_comb begin
		col_next = (WW + 1)'(col_q) + (WW + 1)'(1);
		row_next = {1'b0, row_q} + (HW + 1)'(1);
		eor      = col_next >= {1'b0, act_width};
		eoi      = eor && (row_next >= {1'b0, act_height});
		slot     = col_q >> 1;
		if (slot > LAST_SLOT) begin
			slot = LAST_SLOT;
		end
		wp_inc  = {1'b0, wp_q} + (AW + 1)'(1);
		wp_next = (wp_inc >= (AW + 1)'(LD)) ? '0 : wp_inc[AW-1:0];
	end

	// Build the queue item.
	always_comb begin
		q_write             = accept;
		q_item.opcode       = nv12r_pkg::op_t'(opcode);
		q_item.end_of_row   = is_luma && eor;
		q_item.end_of_image = is_luma && eoi;
		q_item.data         = is_luma ? {8'd0, luma} : {chroma_red, chroma_blue};
		q_addr              = is_luma ? slot[AW-1:0] : wp_q;
	end

	// Advance position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			wp_q  <= '0;
		end else if (accept) begin
			if (!is_luma) begin
				wp_q <= wp_next;
			end else if (eor) begin
				col_q <= '0;
				wp_q  <= '0;
				row_q <= eoi ? '0 : row_next[HW-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

### sv/nv12r_back.sv
// Back end: drains the item queue, keeps the chroma line store, and runs
// the color matrix pipeline into the result queue. Uses nv12r_pkg.
`timescale 1ns / 1ps
`include "nv12_to_rgb_converter_defines.svh"

module nv12r_back #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  nv12r_pkg::item_t                     q_item,
	input  logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] q_addr,
	output logic                                 q_pop,
	input  logic [nv12r_pkg::OUT_CNT_W-1:0]      out_count,
	input  logic                                 channel_order,
	output logic                                 px_write,
	output nv12r_pkg::pixel_t                    px
);

	localparam int LD = MAX_WIDTH / 2;
	localparam int CW = nv12r_pkg::OUT_CNT_W;

	logic [15:0] line_mem [LD];

	// Stage 1: line store read.
	logic        valid_s1;
	logic [7:0]  luma_s1;
	logic        eor_s1;
	logic        eoi_s1;
	logic [15:0] pair_s1;

	// Stage 2: products.
	logic              valid_s2;
	logic              eor_s2;
	logic              eoi_s2;
	nv12r_pkg::acc_t   yc_s2;
	nv12r_pkg::acc_t   rcr_s2;
	nv12r_pkg::acc_t   gcb_s2;
	nv12r_pkg::acc_t   gcr_s2;
	nv12r_pkg::acc_t   bcb_s2;

	logic              is_luma;
	logic              room;
	logic [CW:0]       pending;
	logic              wr_line;
	logic              rd_line;
	nv12r_pkg::sample_t c_val;
	nv12r_pkg::sample_t d_val;
	nv12r_pkg::sample_t e_val;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;

	// Issue a luma item only when the result queue has room for everything in flight.
	assign is_luma = (q_item.opcode == nv12r_pkg::OP_LUMA);
	assign pending = (CW + 1)'(out_count) + (CW + 1)'(valid_s1) + (CW + 1)'(valid_s2);
	assign room    = pending < (CW + 1)'(nv12r_pkg::OUT_DEPTH);
	assign q_pop   = !q_empty && (!is_luma || room);
	assign wr_line = q_pop && !is_luma;
	assign rd_line = q_pop && is_luma;

	// Write chroma pairs; read the pair of the current column pair.
	always_ff @(posedge clk) begin
		if (wr_line) begin
			line_mem[q_addr] <= q_item.data;
		end
		if (rd_line) begin
			pair_s1 <= line_mem[q_addr];
		end
	end

	// Hold stage 1 payload.
	always_ff @(posedge clk) begin
		if (rd_line) begin
			luma_s1 <= q_item.data[7:0];
			eor_s1  <= q_item.end_of_row;
			eoi_s1  <= q_item.end_of_image;
		end
	end

	// Offset the samples and form the products.
	always_comb begin
		c_val = nv12r_pkg::sample_t'({2'b00, luma_s1}) - nv12r_pkg::LUMA_OFFSET;
		d_val = nv12r_pkg::sample_t'({2'b00, pair_s1[7:0]}) - nv12r_pkg::CHROMA_OFFSET;
		e_val = nv12r_pkg::sample_t'({2'b00, pair_s1[15:8]}) - nv12r_pkg::CHROMA_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			yc_s2  <= nv12r_pkg::acc_t'(c_val) * nv12r_pkg::acc_t'(nv12r_pkg::K_LUMA);
			rcr_s2 <= nv12r_pkg::acc_t'(e_val) * nv12r_pkg::acc_t'(nv12r_pkg::K_RED_CR);
			gcb_s2 <= nv12r_pkg::acc_t'(d_val) * nv12r_pkg::acc_t'(nv12r_pkg::K_GREEN_CB);
			gcr_s2 <= nv12r_pkg::acc_t'(e_val) * nv12r_pkg::acc_t'(nv12r_pkg::K_GREEN_CR);
			bcb_s2 <= nv12r_pkg::acc_t'(d_val) * nv12r_pkg::acc_t'(nv12r_pkg::K_BLUE_CB);
			eor_s2 <= eor_s1;
			eoi_s2 <= eoi_s1;
		end
	end

	// Advance pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd_line;
			valid_s2 <= valid_s1;
		end
	end

	// Sum, round, clamp and order the channels.
	always_comb begin
		red   = nv12r_pkg::clamp_q8(yc_s2 + rcr_s2);
		green = nv12r_pkg::clamp_q8(yc_s2 - gcb_s2 - gcr_s2);
		blue  = nv12r_pkg::clamp_q8(yc_s2 + bcb_s2);
		px_write          = valid_s2;
		px.first_channel  = channel_order ? blue : red;
		px.middle_channel = green;
		px.last_channel   = channel_order ? red : blue;
		px.end_of_row     = eor_s2;
		px.end_of_image   = eoi_s2;
	end

	`NV12R_ASSERT_IMPL(a_out_room, valid_s2, out_count < CW'(nv12r_pkg::OUT_DEPTH),
		"result queue overflow")
	`NV12R_ASSERT_NEXT(a_chroma_no_pixel, wr_line, !valid_s1,
		"chroma item entered the pixel pipeline")
	`NV12R_ASSERT_IMPL(a_eoi_on_eor, valid_s2 && eoi_s2, eor_s2,
		"image end without row end")
	`NV12R_ASSERT_NEXT(a_luma_flows, rd_line, valid_s1 && (luma_s1 == $past(q_item.data[7:0])),
		"luma item lost in stage one")

endmodule

### sv/nv12_to_rgb_converter.sv
// NV12 to RGB/BGR converter (BT.601 limited range, Q8). Takes one beat per
// clock while full is low: a chroma beat stores a Cb/Cr pair in the line
// store, a luma beat yields one pixel via the item queue, the registered
// line store read, the registered products and the clamp; a steady stream
// runs at one item per cycle unless a queue stalls. Chroma pairs for a row
// pair must arrive before the even row. The line store holds MAX_WIDTH/2
// entries and is not cleared at reset; its contents are meaningless until
// written. Write configuration only while the block is idle. Depends on
// nv12r_pkg, nv12r_fifo, nv12r_front and nv12r_back.
`timescale 1ns / 1ps

module nv12_to_rgb_converter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [nv12r_pkg::REG_INDEX_W-1:0]    cfg_index,
	input  logic [nv12r_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic [0:0]                           opcode,
	input  logic [7:0]                           luma,
	input  logic [7:0]                           chroma_blue,
	input  logic [7:0]                           chroma_red,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [7:0]                           first_channel,
	output logic [7:0]                           middle_channel,
	output logic [7:0]                           last_channel,
	output logic                                 end_of_row,
	output logic                                 end_of_image
);

	localparam int LD = MAX_WIDTH / 2;
	localparam int AW = (LD > 1) ? $clog2(LD) : 1;
	localparam int MID_W = $bits(nv12r_pkg::item_t) + AW;

	logic [nv12r_pkg::WIDTH_REG_W-1:0]  image_width_q;
	logic [nv12r_pkg::HEIGHT_REG_W-1:0] image_height_q;
	logic                               channel_order_q;

	logic                          fr_write;
	nv12r_pkg::item_t              fr_item;
	logic [AW-1:0]                 fr_addr;
	logic                          mid_full;
	logic                          mid_empty;
	logic                          mid_pop;
	logic [MID_W-1:0]              mid_data;
	nv12r_pkg::item_t              bk_item;
	logic [AW-1:0]                 bk_addr;
	logic                          px_write;
	nv12r_pkg::pixel_t             px;
	nv12r_pkg::pixel_t             out_px;
	logic [nv12r_pkg::OUT_CNT_W-1:0] out_count;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= nv12r_pkg::WIDTH_RESET;
			image_height_q  <= nv12r_pkg::HEIGHT_RESET;
			channel_order_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				nv12r_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[nv12r_pkg::WIDTH_REG_W-1:0];
				end
				nv12r_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[nv12r_pkg::HEIGHT_REG_W-1:0];
				end
				nv12r_pkg::REG_CHANNEL_ORDER: begin
					channel_order_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign full = mid_full;

	nv12r_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (mid_full),
		.opcode       (opcode),
		.luma         (luma),
		.chroma_blue  (chroma_blue),
		.chroma_red   (chroma_red),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.q_write      (fr_write),
		.q_item       (fr_item),
		.q_addr       (fr_addr)
	);

	// Decoupling queue between front and back.
	nv12r_fifo #(
		.WIDTH (MID_W),
		.DEPTH (nv12r_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_write),
		.wr_data ({fr_item, fr_addr}),
		.rd_en   (mid_pop),
		.rd_data (mid_data),
		.full    (mid_full),
		.empty   (mid_empty),
		.count   ()
	);

	assign bk_item = nv12r_pkg::item_t'(mid_data[MID_W-1:AW]);
	assign bk_addr = mid_data[AW-1:0];

	nv12r_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (mid_empty),
		.q_item        (bk_item),
		.q_addr        (bk_addr),
		.q_pop         (mid_pop),
		.out_count     (out_count),
		.channel_order (channel_order_q),
		.px_write      (px_write),
		.px            (px)
	);

	// Result queue toward the consumer.
	nv12r_fifo #(
		.WIDTH ($bits(nv12r_pkg::pixel_t)),
		.DEPTH (nv12r_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (px_write),
		.wr_data (px),
		.rd_en   (pop),
		.rd_data (out_px),
		.full    (),
		.empty   (empty),
		.count   (out_count)
	);

	assign first_channel  = out_px.first_channel;
	assign middle_channel = out_px.middle_channel;
	assign last_channel   = out_px.last_channel;
	assign end_of_row     = out_px.end_of_row;
	assign end_of_image   = out_px.end_of_image;

endmodule

### tb/tb_top.sv
// Self-checking testbench for nv12_to_rgb_converter: queue-fed beat driver, pixel monitor,
// and a BT.601 Q8 pixel predictor that runs as each beat is taken.
// Depends on nv12r_pkg and the converter RTL only.
`timescale 1ns / 1ps

module tb_top;

	localparam int HALF_PERIOD   = 4;
	localparam int MAX_W         = 4096;
	localparam int LINE_ENTRIES  = MAX_W / 2;
	localparam int LANE_CHECK    = 0;
	localparam int LANE_PLAN     = 1;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LONG_HOLD     = 300;
	localparam int RUN_LIMIT_NS  = 5000000;
	localparam logic [nv12r_pkg::REG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef enum {
		PACE_FULL,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH,
		PACE_PRESSURE
	} pace_t;

	typedef struct packed {
		nv12r_pkg::op_t opcode;
		logic [7:0]     luma;
		logic [7:0]     cb;
		logic [7:0]     cr;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [nv12r_pkg::REG_INDEX_W-1:0] cfg_index = '0;
	logic [nv12r_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [0:0] opcode = 1'b0;
	logic [7:0] luma = '0;
	logic [7:0] chroma_blue = '0;
	logic [7:0] chroma_red = '0;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] first_channel;
	logic [7:0] middle_channel;
	logic [7:0] last_channel;
	logic end_of_row;
	logic end_of_image;

	// Two copies of the converter state: one checks taken beats, one plans stimulus.
	logic [15:0] pair_store [2][LINE_ENTRIES];
	bit pair_seen [2][LINE_ENTRIES];
	int unsigned wr_slot [2];
	int unsigned col_pos [2];
	int unsigned row_pos [2];
	logic [nv12r_pkg::WIDTH_REG_W-1:0] width_reg [2];
	logic [nv12r_pkg::HEIGHT_REG_W-1:0] height_reg [2];
	logic order_reg [2];

	beat_t beats_pending [$];
	nv12r_pkg::pixel_t pixels_due [$];
	beat_t offered;
	pace_t pace = PACE_FULL;
	bit row_loaded = 1'b0;
	int unsigned hold_left = 0;
	bit hold_used = 1'b0;
	int mismatches = 0;

	nv12_to_rgb_converter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.luma           (luma),
		.chroma_blue    (chroma_blue),
		.chroma_red     (chroma_red),
		.empty          (empty),
		.pop            (pop),
		.first_channel  (first_channel),
		.middle_channel (middle_channel),
		.last_channel   (last_channel),
		.end_of_row     (end_of_row),
		.end_of_image   (end_of_image)
	);

	always #HALF_PERIOD clk = ~clk;

	// Round, floor-divide by 256, limit to 0..255.
	function automatic logic [7:0] saturate_q8(input int acc);
		int t;
		t = acc + 128;
		if (t < 0)
			return 8'd0;
		t = t / 256;
		if (t > 255)
			return 8'hFF;
		return t[7:0];
	endfunction

	// Effective row length: even, 2..MAX_W.
	function automatic int unsigned row_span(input int lane);
		int unsigned w;
		w = width_reg[lane] & ~13'd1;
		if (w < 2)
			w = 2;
		if (w > MAX_W)
			w = MAX_W;
		return w;
	endfunction

	function automatic void reset_lane(input int lane);
		wr_slot[lane] = 0;
		col_pos[lane] = 0;
		row_pos[lane] = 0;
		width_reg[lane] = nv12r_pkg::WIDTH_RESET;
		height_reg[lane] = nv12r_pkg::HEIGHT_RESET;
		order_reg[lane] = 1'b0;
	endfunction

	function automatic void store_reg(input int lane,
			input logic [nv12r_pkg::REG_INDEX_W-1:0] idx,
			input logic [nv12r_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			nv12r_pkg::REG_IMAGE_WIDTH:
				width_reg[lane] = val[nv12r_pkg::WIDTH_REG_W-1:0];
			nv12r_pkg::REG_IMAGE_HEIGHT:
				height_reg[lane] = val[nv12r_pkg::HEIGHT_REG_W-1:0];
			nv12r_pkg::REG_CHANNEL_ORDER:
				order_reg[lane] = val[0];
			default: ;
		endcase
	endfunction

	// Apply one beat to a lane; returns 1 with the pixel when the beat yields one.
	function automatic bit convert_beat(input int lane, input beat_t b,
			output nv12r_pkg::pixel_t px);
		int unsigned span;
		int unsigned tall;
		int c;
		int d;
		int e;
		logic [15:0] pr;
		logic [7:0] red;
		logic [7:0] grn;
		logic [7:0] blu;
		bit eor;
		bit eoi;
		px = '0;
		if (b.opcode == nv12r_pkg::OP_CHROMA) begin
			pair_store[lane][wr_slot[lane]] = {b.cr, b.cb};
			pair_seen[lane][wr_slot[lane]] = 1'b1;
			wr_slot[lane] = (wr_slot[lane] + 1 >= LINE_ENTRIES) ? 0 : wr_slot[lane] + 1;
			return 1'b0;
		end
		span = row_span(lane);
		tall = (height_reg[lane] == 0) ? 1 : height_reg[lane];
		pr = pair_store[lane][col_pos[lane] >> 1];
		c = int'(b.luma) - 16;
		d = int'(pr[7:0]) - 128;
		e = int'(pr[15:8]) - 128;
		red = saturate_q8(298 * c + 409 * e);
		grn = saturate_q8(298 * c - 100 * d - 208 * e);
		blu = saturate_q8(298 * c + 517 * d);
		eor = (col_pos[lane] + 1 >= span);
		eoi = eor && (row_pos[lane] + 1 >= tall);
		px.first_channel = order_reg[lane] ? blu : red;
		px.middle_channel = grn;
		px.last_channel = order_reg[lane] ? red : blu;
		px.end_of_row = eor;
		px.end_of_image = eoi;
		// Advance position; the row end also rewinds the chroma write slot.
		if (eor) begin
			col_pos[lane] = 0;
			wr_slot[lane] = 0;
			row_pos[lane] = eoi ? 0 : row_pos[lane] + 1;
		end else begin
			col_pos[lane] = col_pos[lane] + 1;
		end
		return 1'b1;
	endfunction

	function automatic bit sender_rests();
		case (pace)
			PACE_SEND_IDLE: return $urandom_range(99) < 84;
			PACE_BOTH:      return $urandom_range(99) < 15;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (pace)
			PACE_RECV_STALL: return $urandom_range(99) < 84;
			PACE_BOTH:       return $urandom_range(99) < 15;
			default:         return 1'b0;
		endcase
	endfunction

	// Sample with extra weight on the extremes.
	function automatic logic [7:0] rand_sample();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Queue a beat and advance the planning copy of the converter state.
	function automatic void queue_beat(input beat_t b);
		nv12r_pkg::pixel_t px;
		if (convert_beat(LANE_PLAN, b, px) && px.end_of_row)
			row_loaded = 1'b0;
		beats_pending.push_back(b);
	endfunction

	function automatic beat_t random_beat(input nv12r_pkg::op_t op);
		beat_t b;
		b.opcode = op;
		b.luma = rand_sample();
		b.cb = rand_sample();
		b.cr = rand_sample();
		return b;
	endfunction

	// Mostly well-formed row pairs with random samples; a few stray beats.
	// A luma beat is only planned once its chroma slot has been written.
	// A row load takes at most half of what is left, so luma follows in wide rows.
	function automatic void plan_stream(input int count);
		int made;
		int unsigned pairs;
		bit slot_ready;
		beat_t b;
		made = 0;
		while (made < count) begin
			slot_ready = pair_seen[LANE_PLAN][col_pos[LANE_PLAN] >> 1];
			if ($urandom_range(99) < 8) begin
				b = random_beat(($urandom_range(1) != 0 && slot_ready) ?
					nv12r_pkg::OP_LUMA : nv12r_pkg::OP_CHROMA);
				queue_beat(b);
				made++;
			end else if (col_pos[LANE_PLAN] == 0 && row_pos[LANE_PLAN] % 2 == 0 && !row_loaded) begin
				pairs = row_span(LANE_PLAN) / 2;
				if (pairs > int'(unsigned'((count - made) / 2)))
					pairs = (count - made) / 2;
				repeat (pairs)
					queue_beat(random_beat(nv12r_pkg::OP_CHROMA));
				made += pairs;
				row_loaded = 1'b1;
			end else begin
				queue_beat(random_beat(slot_ready ? nv12r_pkg::OP_LUMA : nv12r_pkg::OP_CHROMA));
				made++;
			end
		end
	endfunction

	task automatic write_reg(input logic [nv12r_pkg::REG_INDEX_W-1:0] idx,
			input logic [nv12r_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		store_reg(LANE_CHECK, idx, val);
		store_reg(LANE_PLAN, idx, val);
	endtask

	task automatic set_format(input logic [nv12r_pkg::CFG_DATA_W-1:0] w,
			input logic [nv12r_pkg::CFG_DATA_W-1:0] h,
			input logic [nv12r_pkg::CFG_DATA_W-1:0] ord, input bit poke_spare);
		write_reg(nv12r_pkg::REG_IMAGE_WIDTH, w);
		write_reg(nv12r_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(nv12r_pkg::REG_CHANNEL_ORDER, ord);
		if (poke_spare)
			write_reg(REG_SPARE, 16'hFFFF);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait until every beat is taken and every pixel is back, then let chroma beats drain.
	task automatic settle();
		do
			@(posedge clk);
		while (beats_pending.size() != 0 || push || pixels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string field, input int got, input int want);
		if (got != want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Beat driver: predict on each taken beat, then offer the next one.
	always @(posedge clk or negedge arst_n) begin : drive_beats
		nv12r_pkg::pixel_t due;
		if (!arst_n) begin
			push <= 1'b0;
			opcode <= nv12r_pkg::OP_CHROMA;
			luma <= '0;
			chroma_blue <= '0;
			chroma_red <= '0;
		end else begin
			if (push && !full) begin
				if (convert_beat(LANE_CHECK, offered, due))
					pixels_due.push_back(due);
			end
			// Hold the beat while the block is full.
			if (!push || !full) begin
				if (beats_pending.size() != 0 && !sender_rests()) begin
					offered = beats_pending.pop_front();
					push <= 1'b1;
					opcode <= offered.opcode;
					luma <= offered.luma;
					chroma_blue <= offered.cb;
					chroma_red <= offered.cr;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the result side, once, in the pressure phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (pace == PACE_PRESSURE && !hold_used) begin
			hold_left <= LONG_HOLD;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Pixel monitor: check each popped beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : watch_pixels
		nv12r_pkg::pixel_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pixels_due.size() == 0) begin
					mismatches++;
					$display("%0t: pixel with none expected, actual %h_%h_%h eor %b eoi %b",
						$time, first_channel, middle_channel, last_channel,
						end_of_row, end_of_image);
				end else begin
					want = pixels_due.pop_front();
					compare_field("first_channel", first_channel, want.first_channel);
					compare_field("middle_channel", middle_channel, want.middle_channel);
					compare_field("last_channel", last_channel, want.last_channel);
					compare_field("end_of_row", end_of_row, want.end_of_row);
					compare_field("end_of_image", end_of_image, want.end_of_image);
				end
			end
			pop <= (hold_left == 0) && !receiver_stalls();
		end
	end

	initial begin : run_phases
		logic [7:0] corner_cb [8] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h10, 8'hF0, 8'h5A};
		logic [7:0] corner_cr [8] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hF0, 8'h10, 8'hF0};
		logic [7:0] corner_y [16] = '{8'h00, 8'hFF, 8'h10, 8'hEB, 8'hFF, 8'h00, 8'h80, 8'h10,
			8'hFF, 8'hEB, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40};
		beat_t b;
		reset_lane(LANE_CHECK);
		reset_lane(LANE_PLAN);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner chroma pairs and luma extremes under the reset format.
		pace = PACE_FULL;
		for (int i = 0; i < 8; i++) begin
			b.opcode = nv12r_pkg::OP_CHROMA;
			b.luma = 8'h00;
			b.cb = corner_cb[i];
			b.cr = corner_cr[i];
			queue_beat(b);
		end
		for (int i = 0; i < 16; i++) begin
			b.opcode = nv12r_pkg::OP_LUMA;
			b.luma = corner_y[i];
			b.cb = 8'hFF;
			b.cr = 8'hFF;
			queue_beat(b);
		end
		settle();

		// Shrink width mid-row, poke the unused index.
		set_format(16'd2, 16'd3, 16'h0001, 1'b1);
		plan_stream(200);
		settle();

		// Odd width, zero height, high bits on the order value; sender mostly idle.
		set_format(16'd7, 16'd0, 16'hFFFE, 1'b0);
		pace = PACE_SEND_IDLE;
		plan_stream(250);
		settle();

		// Tallest image; receiver mostly stalled.
		set_format(16'd12, 16'hFFFF, 16'h0001, 1'b0);
		pace = PACE_RECV_STALL;
		plan_stream(250);
		settle();

		// Width with masked high bits falls to the minimum; one-row images.
		set_format(16'h2001, 16'd1, 16'h0000, 1'b0);
		pace = PACE_BOTH;
		plan_stream(200);
		settle();

		// Fill the block against a long result hold-off.
		set_format(16'd20, 16'd5, 16'h0001, 1'b0);
		pace = PACE_PRESSURE;
		plan_stream(400);
		settle();

		// Out-of-range width clamps to the widest row; run into it.
		set_format(16'hFFFF, 16'd2, 16'h0000, 1'b0);
		pace = PACE_FULL;
		plan_stream(250);
		settle();

		set_format(16'd10, 16'd4, 16'h0001, 1'b0);
		pace = PACE_BOTH;
		plan_stream(150);
		settle();

		if (mismatches == 0)
			$display("PASS nv12_to_rgb_converter");
		else
			$display("FAIL nv12_to_rgb_converter");
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("FAIL nv12_to_rgb_converter");
		$finish;
	end

endmodule
